### rtl/core/msfl_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the multi-stack free list.
package msfl_pkg;

  // Sizes of the shared store.
  localparam int CAPACITY    = 64;
  localparam int NUM_STACKS  = 4;
  localparam int VALUE_WIDTH = 32;

  // Derived widths. A link holds an entry index or the null code CAPACITY.
  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LINK_W    = $clog2(CAPACITY + 1);
  localparam int SID_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int FUNC_W    = 2;
  localparam int ID_W      = 2;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

  // Function codes on the input channel.
  localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TOP  = 2'd2;

  // Status codes on the output channel.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // Classified operation.
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_TOP,
    OP_NOP
  } op_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    op_t                    op;
    logic [SID_W-1:0]       sid;
    logic [VALUE_WIDTH-1:0] value;
  } cmd_t;

  // A link at or beyond CAPACITY means no entry.
  function automatic logic is_null(logic [LINK_W-1:0] link);
    return link >= NULL_LINK;
  endfunction

  // Fold a stack id into range by repeated subtraction of the stack count.
  function automatic logic [SID_W-1:0] fold_sid(logic [ID_W-1:0] id);
    int v;
    v = int'(id);
    for (int i = 0; i < (1 << ID_W); i++) begin
      if (v >= NUM_STACKS) begin
        v = v - NUM_STACKS;
      end
    end
    return SID_W'(v);
  endfunction

  // Sign-extend a stored value from its width, then take 32 bits.
  function automatic logic [DATA_W-1:0] value_out(logic [VALUE_WIDTH-1:0] v);
    logic signed [VALUE_WIDTH-1:0] sv;
    sv = $signed(v);
    return DATA_W'(sv);
  endfunction

endpackage

### rtl/core/msfl_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read memory with a registered read port.
module msfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/msfl_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, classifies them and queues them for the back end.
module msfl_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [msfl_pkg::FUNC_W-1:0]       func,
  input  logic [msfl_pkg::ID_W-1:0]         stack_id,
  input  logic signed [msfl_pkg::DATA_W-1:0] push_value,
  output logic                              q_valid,
  input  logic                              q_take,
  output msfl_pkg::cmd_t                    q_item
);
  import msfl_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  cmd_t       cmd;

  // Classify the incoming item.
  always_comb begin
    cmd.sid   = fold_sid(stack_id);
    cmd.value = VALUE_WIDTH'($unsigned(push_value));
    case (func)
      FUNC_PUSH: cmd.op = OP_PUSH;
      FUNC_POP:  cmd.op = OP_POP;
      FUNC_TOP:  cmd.op = OP_TOP;
      default:   cmd.op = OP_NOP;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  // Two-entry queue between the front and back ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        slots[wr_ptr] <= cmd;
        wr_ptr        <= !wr_ptr;
      end
      if (q_take) begin
        rd_ptr <= !rd_ptr;
      end
      if (accept && !q_take) begin
        count <= count + 2'd1;
      end else if (!accept && q_take) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/core/msfl_back.sv
`timescale 1ns / 1ps
// Back end: walks the link and value memories and produces one result per item.
module msfl_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  output logic                                q_take,
  input  msfl_pkg::cmd_t                      q_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [msfl_pkg::STATUS_W-1:0]       status,
  output logic signed [msfl_pkg::DATA_W-1:0]  top_value,
  output logic                                store_full,
  output logic                                stack_empty
);
  import msfl_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                  state;
  cmd_t                    cur;
  logic [LINK_W-1:0]       tgt;
  logic                    tgt_null;
  logic                    link_known;
  logic [LINK_W-1:0]       stack_heads [NUM_STACKS];
  logic [LINK_W-1:0]       free_head;
  logic [CAPACITY-1:0]     link_valid;

  logic [LINK_W-1:0]       sel_tgt;
  logic [LINK_W-1:0]       link_rdata;
  logic [VALUE_WIDTH-1:0]  value_rdata;
  logic [LINK_W-1:0]       link_cur;
  logic [LINK_W-1:0]       head_cur;
  logic                    done;
  logic                    link_we;
  logic [LINK_W-1:0]       link_wdata;
  logic                    value_we;
  logic [LINK_W-1:0]       free_head_next;
  logic [LINK_W-1:0]       head_next;
  logic [STATUS_W-1:0]     status_next;
  logic [DATA_W-1:0]       top_next;

  // Pick the entry the queued item works on: free head for a push, stack head otherwise.
  assign q_take  = (state == S_IDLE) && q_valid;
  assign sel_tgt = (q_item.op == OP_PUSH) ? free_head : stack_heads[q_item.sid];

  // Link memory; entries never written read their reset link i+1.
  msfl_ram #(
    .WIDTH(LINK_W),
    .DEPTH(CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (tgt[ADDR_W-1:0]),
    .wdata (link_wdata),
    .re    (q_take),
    .raddr (sel_tgt[ADDR_W-1:0]),
    .rdata (link_rdata)
  );

  // Value memory.
  msfl_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .waddr (tgt[ADDR_W-1:0]),
    .wdata (cur.value),
    .re    (q_take),
    .raddr (sel_tgt[ADDR_W-1:0]),
    .rdata (value_rdata)
  );

  // Second step: work out the new heads, the memory write and the result.
  always_comb begin
    done           = (state == S_EXEC) && (!out_valid || !out_stall);
    link_cur       = link_known ? link_rdata : (tgt + LINK_W'(1));
    head_cur       = stack_heads[cur.sid];
    free_head_next = free_head;
    head_next      = head_cur;
    status_next    = ST_OK;
    top_next       = '0;
    link_we        = 1'b0;
    link_wdata     = head_cur;
    value_we       = 1'b0;
    case (cur.op)
      OP_PUSH: begin
        if (tgt_null) begin
          status_next = ST_OVERFLOW;
        end else begin
          free_head_next = link_cur;
          head_next      = tgt;
          link_we        = done;
          link_wdata     = head_cur;
          value_we       = done;
        end
      end
      OP_POP: begin
        if (tgt_null) begin
          status_next = ST_UNDERFLOW;
          top_next    = '1;
        end else begin
          head_next      = link_cur;
          free_head_next = tgt;
          link_we        = done;
          link_wdata     = free_head;
        end
      end
      OP_TOP: begin
        if (tgt_null) begin
          status_next = ST_UNDERFLOW;
          top_next    = '1;
        end else begin
          top_next = value_out(value_rdata);
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer, list state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      free_head  <= '0;
      link_valid <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_heads[i] <= NULL_LINK;
      end
    end else begin
      // A taken result clears the output unless a new one loads in the same cycle.
      if (out_valid && !out_stall && !done) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_take) begin
            cur        <= q_item;
            tgt        <= sel_tgt;
            tgt_null   <= is_null(sel_tgt);
            link_known <= link_valid[sel_tgt[ADDR_W-1:0]];
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (done) begin
            free_head            <= free_head_next;
            stack_heads[cur.sid] <= head_next;
            if (link_we) begin
              link_valid[tgt[ADDR_W-1:0]] <= 1'b1;
            end
            out_valid   <= 1'b1;
            status      <= status_next;
            top_value   <= $signed(top_next);
            store_full  <= is_null(free_head_next);
            stack_empty <= is_null(head_next);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/multi_stack_free_list.sv
`timescale 1ns / 1ps
// Top level of the multi-stack free list: front end, queue and back end.
//
//   Channel  Handshake            Fields
//   input    in_valid / in_stall  func, stack_id, push_value
//   output   out_valid / out_stall status, top_value, store_full, stack_empty
//
// In the back end, each item first reads the link and value memories at the chosen entry,
// then writes the link memory (push, pop) and the value memory (push), and loads the result register.
// Link entries not yet written read their reset link through a flag per entry,
// so no clearing pass runs.
// A two-entry queue lets the input side keep accepting while a result is stalled, until the queue is full.
module multi_stack_free_list (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [msfl_pkg::FUNC_W-1:0]         func,
  input  logic [msfl_pkg::ID_W-1:0]           stack_id,
  input  logic signed [msfl_pkg::DATA_W-1:0]  push_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [msfl_pkg::STATUS_W-1:0]       status,
  output logic signed [msfl_pkg::DATA_W-1:0]  top_value,
  output logic                                store_full,
  output logic                                stack_empty
);
  import msfl_pkg::*;

  logic q_valid;
  logic q_take;
  cmd_t q_item;

  msfl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .stack_id   (stack_id),
    .push_value (push_value),
    .q_valid    (q_valid),
    .q_take     (q_take),
    .q_item     (q_item)
  );

  msfl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_take      (q_take),
    .q_item      (q_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .top_value   (top_value),
    .store_full  (store_full),
    .stack_empty (stack_empty)
  );

  // An overflow can only be reported while the store is full.
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OVERFLOW) |-> store_full)
    else $error("overflow reported with free entries left");

  // An underflow leaves the stack empty and reports all ones.
  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_UNDERFLOW) |-> stack_empty && (top_value == -1))
    else $error("underflow result inconsistent");

endmodule

### bench/tb_multi_stack_free_list.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-stack free list: directed table, then random operations.
module tb_multi_stack_free_list;
  import msfl_pkg::*;

  // The operation code that does nothing; the package names only the other three.
  localparam logic [FUNC_W-1:0] FUNC_NOP      = 2'd3;
  localparam logic [DATA_W-1:0] TOP_UNDERFLOW = '1;
  localparam int RANDOM_ITEMS = 1325;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   top_value;
    logic                store_full;
    logic                stack_empty;
  } stack_result_t;

  // One directed row. Where typed is set, the expected result is taken from the row.
  typedef struct packed {
    logic [FUNC_W-1:0]   f;
    logic [ID_W-1:0]     sid;
    logic [DATA_W-1:0]   value;
    logic                typed;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   top_value;
    logic                store_full;
    logic                stack_empty;
  } probe_row_t;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } op_mix_t;

  localparam int PROBE_ROWS = 24;
  localparam probe_row_t PROBE_TABLE [PROBE_ROWS] = '{
    // Empty stacks right after reset, and an unused code.
    '{FUNC_POP,  2'd0, 32'h0,        1'b1, ST_UNDERFLOW, TOP_UNDERFLOW, 1'b0, 1'b1},
    '{FUNC_TOP,  2'd3, 32'h0,        1'b1, ST_UNDERFLOW, TOP_UNDERFLOW, 1'b0, 1'b1},
    '{FUNC_NOP,  2'd1, 32'hFFFFFFFF, 1'b1, ST_OK,        32'h0,         1'b0, 1'b1},
    // Extreme values on each stack, read back by top.
    '{FUNC_PUSH, 2'd0, 32'h7FFFFFFF, 1'b1, ST_OK,        32'h0,         1'b0, 1'b0},
    '{FUNC_TOP,  2'd0, 32'h0,        1'b1, ST_OK,        32'h7FFFFFFF,  1'b0, 1'b0},
    '{FUNC_PUSH, 2'd1, 32'h80000000, 1'b1, ST_OK,        32'h0,         1'b0, 1'b0},
    '{FUNC_TOP,  2'd1, 32'h0,        1'b1, ST_OK,        32'h80000000,  1'b0, 1'b0},
    '{FUNC_PUSH, 2'd2, 32'hFFFFFFFF, 1'b1, ST_OK,        32'h0,         1'b0, 1'b0},
    '{FUNC_TOP,  2'd2, 32'h0,        1'b1, ST_OK,        32'hFFFFFFFF,  1'b0, 1'b0},
    '{FUNC_PUSH, 2'd3, 32'h0,        1'b1, ST_OK,        32'h0,         1'b0, 1'b0},
    '{FUNC_TOP,  2'd3, 32'h0,        1'b1, ST_OK,        32'h0,         1'b0, 1'b0},
    // Second entry on one stack, then unwind it past empty.
    '{FUNC_PUSH, 2'd0, 32'hA5A5A5A5, 1'b0, ST_OK,        32'h0,         1'b0, 1'b0},
    '{FUNC_TOP,  2'd0, 32'h0,        1'b0, ST_OK,        32'h0,         1'b0, 1'b0},
    '{FUNC_POP,  2'd0, 32'h0,        1'b1, ST_OK,        32'h0,         1'b0, 1'b0},
    '{FUNC_TOP,  2'd0, 32'h0,        1'b1, ST_OK,        32'h7FFFFFFF,  1'b0, 1'b0},
    '{FUNC_POP,  2'd0, 32'h0,        1'b1, ST_OK,        32'h0,         1'b0, 1'b1},
    '{FUNC_POP,  2'd0, 32'h0,        1'b1, ST_UNDERFLOW, TOP_UNDERFLOW, 1'b0, 1'b1},
    '{FUNC_NOP,  2'd2, 32'h12345678, 1'b1, ST_OK,        32'h0,         1'b0, 1'b0},
    '{FUNC_POP,  2'd1, 32'h0,        1'b1, ST_OK,        32'h0,         1'b0, 1'b1},
    '{FUNC_POP,  2'd2, 32'h0,        1'b1, ST_OK,        32'h0,         1'b0, 1'b1},
    '{FUNC_POP,  2'd3, 32'h0,        1'b1, ST_OK,        32'h0,         1'b0, 1'b1},
    // Freed entries are reused.
    '{FUNC_PUSH, 2'd3, 32'h5A5AC3C3, 1'b0, ST_OK,        32'h0,         1'b0, 1'b0},
    '{FUNC_TOP,  2'd3, 32'h0,        1'b0, ST_OK,        32'h0,         1'b0, 1'b0},
    '{FUNC_NOP,  2'd0, 32'h0,        1'b1, ST_OK,        32'h0,         1'b0, 1'b1}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   func = '0;
  logic [ID_W-1:0]     stack_id = '0;
  logic [DATA_W-1:0]   push_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   top_value;
  logic                store_full;
  logic                stack_empty;

  logic                calm = 1'b0;
  int                  errors = 0;
  int                  quiet_cycles = 0;
  stack_result_t       pending_results [$];

  // Shadow copy of the shared store.
  logic [VALUE_WIDTH-1:0] shadow_value [CAPACITY];
  logic [LINK_W-1:0]      shadow_link [CAPACITY];
  logic [LINK_W-1:0]      shadow_head [NUM_STACKS];
  logic [LINK_W-1:0]      shadow_free;

  multi_stack_free_list dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .stack_id(stack_id),
    .push_value(push_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .top_value(top_value),
    .store_full(store_full),
    .stack_empty(stack_empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Put the shadow store in its reset state: every entry chained on the free list.
  function automatic void clear_shadow_store();
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_value[i] = '0;
      shadow_link[i]  = LINK_W'(i + 1);
    end
    for (int i = 0; i < NUM_STACKS; i++) begin
      shadow_head[i] = LINK_W'(CAPACITY);
    end
    shadow_free = '0;
  endfunction

  // Apply one operation to the shadow store and work out the result it gives.
  function automatic stack_result_t apply_stack_op(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                                   logic [DATA_W-1:0] v);
    stack_result_t     r;
    logic [SID_W-1:0]  s;
    logic [LINK_W-1:0] e;
    s = fold_sid(id);
    r = '0;
    r.status = ST_OK;
    case (f)
      FUNC_PUSH: begin
        if (shadow_free >= CAPACITY) begin
          r.status = ST_OVERFLOW;
        end else begin
          e = shadow_free;
          shadow_free = shadow_link[e[ADDR_W-1:0]];
          shadow_link[e[ADDR_W-1:0]] = shadow_head[s];
          shadow_head[s] = e;
          shadow_value[e[ADDR_W-1:0]] = v[VALUE_WIDTH-1:0];
        end
      end
      FUNC_POP: begin
        if (shadow_head[s] >= CAPACITY) begin
          r.status = ST_UNDERFLOW;
          r.top_value = TOP_UNDERFLOW;
        end else begin
          e = shadow_head[s];
          shadow_head[s] = shadow_link[e[ADDR_W-1:0]];
          shadow_link[e[ADDR_W-1:0]] = shadow_free;
          shadow_free = e;
          shadow_value[e[ADDR_W-1:0]] = '0;
        end
      end
      FUNC_TOP: begin
        if (shadow_head[s] >= CAPACITY) begin
          r.status = ST_UNDERFLOW;
          r.top_value = TOP_UNDERFLOW;
        end else begin
          e = shadow_head[s];
          r.top_value = DATA_W'($signed(shadow_value[e[ADDR_W-1:0]]));
        end
      end
      default: begin
      end
    endcase
    r.store_full  = (shadow_free >= CAPACITY);
    r.stack_empty = (shadow_head[s] >= CAPACITY);
    return r;
  endfunction

  // Push values lean on the extremes now and then.
  function automatic logic [DATA_W-1:0] pick_push_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'hFFFFFFFF;
      3: return 32'h0;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Offer one item and return at the edge where it is accepted.
  task automatic offer_item(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id, logic [DATA_W-1:0] v);
    while (!calm && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    stack_id   <= id;
    push_value <= v;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Stimulus: reset, directed table, random runs that fill and drain the store.
  initial begin
    stack_result_t     predicted;
    op_mix_t           mix;
    int                run_left;
    int                roll;
    int                push_cut;
    int                pop_cut;
    logic [FUNC_W-1:0] f;
    clear_shadow_store();
    mix = MIX_EVEN;
    run_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PROBE_ROWS; i++) begin
      offer_item(PROBE_TABLE[i].f, PROBE_TABLE[i].sid, PROBE_TABLE[i].value);
      predicted = apply_stack_op(PROBE_TABLE[i].f, PROBE_TABLE[i].sid, PROBE_TABLE[i].value);
      if (PROBE_TABLE[i].typed) begin
        predicted.status      = PROBE_TABLE[i].status;
        predicted.top_value   = PROBE_TABLE[i].top_value;
        predicted.store_full  = PROBE_TABLE[i].store_full;
        predicted.stack_empty = PROBE_TABLE[i].stack_empty;
      end
      pending_results.push_back(predicted);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (run_left == 0) begin
        mix = op_mix_t'($urandom_range(0, 2));
        run_left = $urandom_range(40, 160);
      end
      run_left--;
      calm <= (n >= 500 && n < 750);
      case (mix)
        MIX_FILL: begin
          push_cut = 75;
          pop_cut  = 85;
        end
        MIX_DRAIN: begin
          push_cut = 15;
          pop_cut  = 80;
        end
        default: begin
          push_cut = 35;
          pop_cut  = 65;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_cut) begin
        f = FUNC_PUSH;
      end else if (roll < pop_cut) begin
        f = FUNC_POP;
      end else if (roll < 95) begin
        f = FUNC_TOP;
      end else begin
        f = FUNC_NOP;
      end
      offer_item(f, ID_W'($urandom_range(0, 3)), pick_push_value());
      pending_results.push_back(apply_stack_op(f, stack_id, push_value));
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver stalls at random outside the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 23);
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d top %h", $realtime, status,
                 top_value);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status, status);
          errors++;
        end
        if (top_value !== want.top_value) begin
          $display("%0t: top_value expected %h actual %h", $realtime, want.top_value, top_value);
          errors++;
        end
        if (store_full !== want.store_full) begin
          $display("%0t: store_full expected %b actual %b", $realtime, want.store_full,
                   store_full);
          errors++;
        end
        if (stack_empty !== want.stack_empty) begin
          $display("%0t: stack_empty expected %b actual %b", $realtime, want.stack_empty,
                   stack_empty);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any item moving on either side ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
